@@ rtl/lsp_pkg.sv @@
`timescale 1ns / 1ps

package lsp_pkg;

   // Fixed point format of the incoming samples
   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 17;
   localparam int X_W       = FRAC_BITS + 1;          // clamped level, 0 .. 1.0
   localparam int CMP_W     = (IN_W > X_W + 1) ? IN_W : X_W + 1;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = 1 << (FRAC_BITS - 1);
   localparam int CODES     = 256;
   localparam int BIG_W     = 384;                    // exact threshold math, elaboration only

   typedef logic signed [IN_W-1:0]     sample_type;
   typedef logic [X_W-1:0]             level_type;
   typedef logic [7:0]                 code_type;
   typedef logic [CODES-2:0][X_W-1:0]  thr_table_type;

   // Clamp a signed sample to [0, 1.0]
   function automatic level_type clamp_f(input sample_type v);
      logic signed [CMP_W-1:0] w;
      logic signed [CMP_W-1:0] one_w;
      w     = CMP_W'(v);
      one_w = CMP_W'(ONE);
      if (w < 0) begin
         return '0;
      end else if (w > one_w) begin
         return X_W'(ONE);
      end else begin
         return X_W'(w);
      end
   endfunction

   // Does linear level x reach the decision point between codes k and k+1
   function automatic logic reaches_f(input logic [BIG_W-1:0] x, input int k);
      logic [BIG_W-1:0] one;
      logic [BIG_W-1:0] lhs;
      logic [BIG_W-1:0] rhs;
      logic [BIG_W-1:0] a;
      one = BIG_W'(1) << FRAC_BITS;
      if (x * BIG_W'(10000000) < BIG_W'(31308) * one) begin
         return (BIG_W'(658920) * x >= BIG_W'(2 * k + 1) * BIG_W'(100) * one);
      end
      a   = BIG_W'(2000 * k + 29050);
      lhs = BIG_W'(1);
      rhs = BIG_W'(1);
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * x;
      end
      for (int i = 0; i < 12; i++) begin
         lhs = lhs * BIG_W'(538050);
      end
      for (int i = 0; i < 12; i++) begin
         rhs = rhs * a;
      end
      for (int i = 0; i < 5; i++) begin
         rhs = rhs * one;
      end
      return (lhs >= rhs);
   endfunction

   // Smallest level that reaches each code step; built at elaboration
   function automatic thr_table_type make_thr_f();
      thr_table_type    t;
      logic [BIG_W-1:0] lo;
      logic [BIG_W-1:0] hi;
      logic [BIG_W-1:0] mid;
      for (int k = 0; k < CODES - 1; k++) begin
         lo = '0;
         hi = BIG_W'(ONE);
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (reaches_f(mid, k)) begin
               hi = mid;
            end else begin
               lo = mid + BIG_W'(1);
            end
         end
         t[k] = X_W'(lo);
      end
      return t;
   endfunction

   localparam thr_table_type THR = make_thr_f();

endpackage

@@ rtl/linear_to_srgb_pixel_pack_unit.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// -------   ------------------------   --------------------------------------------
// req       req_valid / req_stall      req_red_linear, req_green_linear,
//                                      req_blue_linear, req_alpha_level (s17, Q.14)
// rsp       rsp_valid / rsp_stall      rsp_packed_pixel {A, B, G, R} sRGB bytes
//
// One request per clock sustained while rsp_stall is low. Path: a request register,
// then the clamp / threshold search / alpha scale logic, then the result register.
// Reset (synchronous, active high) empties both stages.
// A stalled result holds in the result register while the request register
// keeps one more request; req_stall rises only when both are full.

module linear_to_srgb_pixel_pack_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lsp_pkg::sample_type req_red_linear,
   input  lsp_pkg::sample_type req_green_linear,
   input  lsp_pkg::sample_type req_blue_linear,
   input  lsp_pkg::sample_type req_alpha_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_packed_pixel
);
   import lsp_pkg::*;

   localparam int PROD_W = X_W + 8;

   // request stage
   logic       s1_valid_ff, s1_valid_in;
   sample_type red_ff, green_ff, blue_ff, alpha_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] pixel_ff, pixel_in;

   logic take_req;
   logic load_rsp;

   code_type          red_code, green_code, blue_code, alpha_code;
   level_type         alpha_lvl;
   logic [PROD_W-1:0] alpha_prod;

   // result register moves when empty or being taken
   assign load_rsp  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !load_rsp;
   assign take_req  = req_valid && !req_stall;

   lsp_encode u_red   (.sample(red_ff),   .code(red_code));
   lsp_encode u_green (.sample(green_ff), .code(green_code));
   lsp_encode u_blue  (.sample(blue_ff),  .code(blue_code));

   // alpha: round(255 * a), halves up
   assign alpha_lvl  = clamp_f(alpha_ff);
   assign alpha_prod = PROD_W'(alpha_lvl) * PROD_W'(255) + PROD_W'(HALF);
   assign alpha_code = alpha_prod[FRAC_BITS +: 8];

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      if (load_rsp) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            pixel_in = {alpha_code, blue_code, green_code, red_code};
         end
      end
      if (take_req) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      if (take_req) begin
         red_ff   <= req_red_linear;
         green_ff <= req_green_linear;
         blue_ff  <= req_blue_linear;
         alpha_ff <= req_alpha_level;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_pixel = pixel_ff;

endmodule

@@ rtl/lsp_encode.sv @@
`timescale 1ns / 1ps

module lsp_encode (
   input  lsp_pkg::sample_type sample,
   output lsp_pkg::code_type   code
);
   import lsp_pkg::*;

   level_type        level;
   logic [CODES-2:0] above;
   code_type         code_v;
   code_type         cand;

   assign level = clamp_f(sample);

   // thermometer of all code steps
   always_comb begin
      for (int k = 0; k < CODES - 1; k++) begin
         above[k] = (level >= THR[k]);
      end
   end

   // bit-by-bit search over the thermometer, MSB first
   always_comb begin
      code_v = '0;
      cand   = '0;
      for (int b = 7; b >= 0; b--) begin
         cand = code_v | (code_type'(1) << b);
         if (above[cand - code_type'(1)]) begin
            code_v = cand;
         end
      end
   end

   assign code = code_v;

endmodule

@@ rtl/lsp_checker.sv @@
`timescale 1ns / 1ps

module lsp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [31:0]         rsp_packed_pixel
);

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_pixel))
      else $error("stalled result changed");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // input only stalls when the output side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled with free output");

   // accepted request passes the request and result registers to the output when not blocked
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted request lost");

endmodule

bind linear_to_srgb_pixel_pack_unit lsp_checker u_lsp_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Gamma-encode / pack checker for linear_to_srgb_pixel_pack_unit.
// Each accepted request is scored against an exact integer model of the sRGB
// code decision: a binary search over the 256 codes, with the power segment
// decided by comparing x^5 * 538050^12 against A^12 * 2^(5F) in 384-bit math.

module testbench;
   import lsp_pkg::*;

   typedef logic [383:0] wide_type;

   // One directed request; word is only trusted when known is set
   typedef struct packed {
      sample_type  red;
      sample_type  green;
      sample_type  blue;
      sample_type  alpha;
      logic        known;
      logic [31:0] word;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sample_type  req_red_linear = '0;
   sample_type  req_green_linear = '0;
   sample_type  req_blue_linear = '0;
   sample_type  req_alpha_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_packed_pixel;

   logic [31:0] expected_pixels [$];
   row_type     directed_rows [$];
   int          mismatches = 0;
   bit          steady = 1'b0;        // no idling on either side while set

   // x^5 of a level is scaled by this; code step k compares against step_rhs[k]
   wide_type    pow_scale;
   wide_type    step_rhs [0:CODES-2];

   linear_to_srgb_pixel_pack_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_linear   (req_red_linear),
      .req_green_linear (req_green_linear),
      .req_blue_linear  (req_blue_linear),
      .req_alpha_level  (req_alpha_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_pixel (rsp_packed_pixel)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic wide_type raise(input wide_type base, input int n);
      wide_type acc;
      acc = 384'd1;
      for (int i = 0; i < n; i++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

   function automatic level_type clamp_level(input sample_type v);
      if (v < 0) begin
         return '0;
      end
      if (v > ONE) begin
         return level_type'(ONE);
      end
      return level_type'(v);
   endfunction

   // Has level x crossed the decision point between codes k and k+1?
   // Below 0.0031308 the linear segment decides; above it the exact power test.
   function automatic bit crosses_step(input level_type x, input wide_type x_pow, input int k);
      longint unsigned xl;
      longint unsigned lin_rhs;
      xl = 64'(x);
      if (xl * 64'd10000000 < (64'd31308 << FRAC_BITS)) begin
         lin_rhs = (64'(2 * k + 1) * 64'd100) << FRAC_BITS;
         return (64'd658920 * xl >= lin_rhs);
      end
      return (x_pow >= step_rhs[k]);
   endfunction

   function automatic code_type srgb_byte(input sample_type v);
      level_type x;
      wide_type  x_pow;
      int        lo;
      int        hi;
      int        mid;
      x = clamp_level(v);
      if (x == 0) begin
         return 8'd0;
      end
      x_pow = pow_scale * raise(wide_type'(x), 5);
      lo = 0;
      hi = CODES - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (crosses_step(x, x_pow, mid - 1)) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return code_type'(lo);
   endfunction

   // round(255 * a), halves up
   function automatic code_type alpha_byte(input sample_type v);
      int x;
      x = int'(clamp_level(v));
      return code_type'((255 * x + HALF) >> FRAC_BITS);
   endfunction

   function automatic logic [31:0] pixel_word(input sample_type r, input sample_type g,
                                              input sample_type b, input sample_type a);
      return {alpha_byte(a), srgb_byte(b), srgb_byte(g), srgb_byte(r)};
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Random level: mostly in range, with the bottom codes, the region near
   // full scale and the whole 17-bit range (negatives, overrange) mixed in.
   function automatic sample_type rand_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         return sample_type'($urandom);
      end
      if (pick < 70) begin
         return sample_type'($urandom_range(0, ONE));
      end
      if (pick < 85) begin
         return sample_type'($urandom_range(0, 120));
      end
      return sample_type'(ONE - 64 + $urandom_range(0, 128));
   endfunction

   task automatic add_row(input int r, input int g, input int b, input int a,
                          input bit known, input logic [31:0] word);
      row_type row;
      row.red   = sample_type'(r);
      row.green = sample_type'(g);
      row.blue  = sample_type'(b);
      row.alpha = sample_type'(a);
      row.known = known;
      row.word  = word;
      directed_rows.push_back(row);
   endtask

   // Entered and left at a falling edge. Idle cycles put junk on the payload
   // with valid low; the request then holds until it is taken.
   task automatic send_pixel(input sample_type r, input sample_type g, input sample_type b,
                             input sample_type a, input bit known, input logic [31:0] word);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_valid        <= 1'b0;
         req_red_linear   <= sample_type'($urandom);
         req_green_linear <= sample_type'($urandom);
         req_blue_linear  <= sample_type'($urandom);
         req_alpha_level  <= sample_type'($urandom);
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_red_linear   <= r;
      req_green_linear <= g;
      req_blue_linear  <= b;
      req_alpha_level  <= a;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_pixels.push_back(known ? word : pixel_word(r, g, b, a));
      @(negedge clock);
   endtask

   // Sender goes quiet until every outstanding pixel has come back.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Receiver back-pressure, changed at the falling edge only
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 16);
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $time,
                     rsp_packed_pixel);
            mismatches++;
         end else begin
            if (rsp_packed_pixel !== expected_pixels[0]) begin
               $display("%0t: packed_pixel mismatch, expected %h, actual %h", $time,
                        expected_pixels[0], rsp_packed_pixel);
               mismatches++;
            end
            void'(expected_pixels.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      row_type row;

      // Per-code right-hand sides of the power-segment test, (2000k+29050)^12 << 5F
      pow_scale = raise(384'd538050, 12);
      for (int k = 0; k < CODES - 1; k++) begin
         step_rhs[k] = raise(wide_type'(2000 * k + 29050), 12) << (5 * FRAC_BITS);
      end

      //       red      green    blue     alpha   known  word
      add_row(0,       0,       0,       0,      1'b1,  32'h0000_0000);
      add_row(ONE,     ONE,     ONE,     ONE,    1'b1,  32'hFFFF_FFFF);
      add_row(65535,   65535,   65535,   65535,  1'b1,  32'hFFFF_FFFF);   // top of range
      add_row(-65536,  -65536,  -65536,  -65536, 1'b1,  32'h0000_0000);   // bottom of range
      add_row(-1,      -1,      -1,      -1,     1'b1,  32'h0000_0000);
      add_row(ONE,     0,       0,       0,      1'b1,  32'h0000_00FF);   // byte lanes
      add_row(0,       ONE,     0,       0,      1'b1,  32'h0000_FF00);
      add_row(0,       0,       ONE,     0,      1'b1,  32'h00FF_0000);
      add_row(0,       0,       0,       ONE,    1'b1,  32'hFF00_0000);
      add_row(ONE + 1, -1,      65535,   -65536, 1'b1,  32'h00FF_00FF);   // clamp both ways
      add_row(1,       2,       3,       32,     1'b0,  '0);              // first code steps
      add_row(50,      51,      52,      64,     1'b0,  '0);              // segment switch
      add_row(53,      200,     1000,    127,    1'b0,  '0);
      add_row(8192,    4096,    16383,   8192,   1'b0,  '0);              // alpha half
      add_row(16383,   16382,   16000,   16383,  1'b0,  '0);              // just under one
      add_row(-65536,  65535,   8192,    -1,     1'b0,  '0);
      add_row(100,     10000,   12345,   ONE+1,  1'b0,  '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_pixel(row.red, row.green, row.blue, row.alpha, row.known, row.word);
      end
      drain_pixels();

      for (int n = 0; n < 1750; n++) begin
         steady <= (n >= 700 && n < 1000);   // back-to-back stretch, no stalls
         if (n == 1200) begin
            drain_pixels();
         end
         send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b0, '0);
      end

      drain_pixels();
      repeat (6) @(negedge clock);   // catch any stray result past the two-stage pipe
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
